// ===== rtl/core/cnrs_pkg.sv =====
// ----------------------------------------------------------------------------
// cnrs_pkg
// Types, codes and constants shared by the client notify retry scheduler.
// ----------------------------------------------------------------------------
package cnrs_pkg;

  localparam int unsigned MaxClientsDefault = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [15:0] TimeoutReset = 16'd100;
  localparam logic [15:0] PauseReset = 16'd200;
  localparam logic [15:0] PeriodReset = 16'd400;
  localparam logic [7:0] AddrEmpty = 8'hff;

  localparam logic [CfgIdxW-1:0] RegTimeout = 2'd0;
  localparam logic [CfgIdxW-1:0] RegPause = 2'd1;
  localparam logic [CfgIdxW-1:0] RegPeriod = 2'd2;

  typedef enum logic [1:0] {
    CMD_POLL = 2'd0,
    CMD_CONFIRM = 2'd1,
    CMD_LOAD = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    PH_SEND = 2'd0,
    PH_WAIT = 2'd1,
    PH_OK = 2'd2,
    PH_DONE = 2'd3
  } phase_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_CLEAR,
    ST_GATE,
    ST_SERVE,
    ST_SEARCH,
    ST_CONFIRM,
    ST_LOAD,
    ST_DONE
  } state_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [15:0] now_ms;
    logic        snapshot_differs;
    logic        send_ready;
    logic [7:0]  sender_address;
    logic        payload_matches;
    logic [3:0]  slot;
    logic [7:0]  client_address;
    logic [7:0]  max_retries;
  } in_t;

  typedef struct packed {
    logic       send_request;
    logic [7:0] dest_address;
    logic       change_checked;
    logic       round_active;
  } out_t;

  typedef struct packed {
    logic latch_in;
    logic set_checked;
    logic start_round;
    logic idx_zero;
    logic idx_cursor;
    logic idx_search_start;
    logic idx_next;
    logic clear_entry;
    logic pause_clear;
    logic send_entry;
    logic retry_entry;
    logic done_entry;
    logic search_hit;
    logic round_end;
    logic confirm_entry;
    logic load_entry;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    cmd_e   cmd;
    logic   any_valid;
    logic   check_due;
    logic   differs;
    logic   active;
    logic   pause_wait;
    logic   entry_valid;
    phase_e entry_phase;
    logic   send_ready;
    logic   timeout_due;
    logic   retry_avail;
    logic   addr_match;
    logic   payload_matches;
    logic   idx_last;
    logic   k_last;
    logic   slot_ok;
    logic   out_free;
  } status_t;

endpackage

// ===== rtl/core/cnrs_ctrl.sv =====
// ----------------------------------------------------------------------------
// cnrs_ctrl
// Sequencer that walks one transaction through the scheduler datapath.
// ----------------------------------------------------------------------------
module cnrs_ctrl import cnrs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  status_t st_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_stall_o = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        case (st_i.cmd)
          CMD_POLL: begin
            if (!st_i.any_valid) begin
              state_d = ST_DONE;
            end else if (st_i.check_due) begin
              cmd_o.set_checked = 1'b1;
              if (st_i.differs) begin
                cmd_o.start_round = 1'b1;
                cmd_o.idx_zero = 1'b1;
                state_d = ST_CLEAR;
              end else begin
                state_d = ST_GATE;
              end
            end else begin
              state_d = ST_GATE;
            end
          end
          CMD_CONFIRM: begin
            cmd_o.idx_zero = 1'b1;
            state_d = ST_CONFIRM;
          end
          CMD_LOAD: state_d = ST_LOAD;
          default: state_d = ST_DONE;
        endcase
      end
      ST_CLEAR: begin
        cmd_o.clear_entry = 1'b1;
        if (st_i.idx_last) begin
          state_d = ST_GATE;
        end else begin
          cmd_o.idx_next = 1'b1;
        end
      end
      ST_GATE: begin
        if (!st_i.active || st_i.pause_wait) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.pause_clear = 1'b1;
          cmd_o.idx_cursor = 1'b1;
          state_d = ST_SERVE;
        end
      end
      ST_SERVE: begin
        cmd_o.idx_search_start = 1'b1;
        state_d = ST_SEARCH;
        if (st_i.entry_valid) begin
          case (st_i.entry_phase)
            PH_SEND: begin
              if (st_i.send_ready) begin
                cmd_o.send_entry = 1'b1;
              end else begin
                cmd_o.idx_search_start = 1'b0;
                state_d = ST_DONE;
              end
            end
            PH_WAIT: begin
              if (st_i.timeout_due) begin
                if (st_i.retry_avail) begin
                  cmd_o.retry_entry = 1'b1;
                  cmd_o.idx_search_start = 1'b0;
                  state_d = ST_DONE;
                end else begin
                  cmd_o.done_entry = 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_SEARCH: begin
        if (st_i.entry_valid &&
            (st_i.entry_phase == PH_SEND || st_i.entry_phase == PH_WAIT)) begin
          cmd_o.search_hit = 1'b1;
          state_d = ST_DONE;
        end else if (st_i.k_last) begin
          cmd_o.round_end = 1'b1;
          state_d = ST_DONE;
        end else begin
          cmd_o.idx_next = 1'b1;
        end
      end
      ST_CONFIRM: begin
        if (st_i.entry_valid && st_i.addr_match && st_i.entry_phase == PH_WAIT) begin
          cmd_o.confirm_entry = st_i.payload_matches;
          state_d = ST_DONE;
        end else if (st_i.idx_last) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.idx_next = 1'b1;
        end
      end
      ST_LOAD: begin
        cmd_o.load_entry = st_i.slot_ok;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (st_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/cnrs_dp.sv =====
// ----------------------------------------------------------------------------
// cnrs_dp
// Client table, timers, round state and result register of the scheduler.
// ----------------------------------------------------------------------------
module cnrs_dp import cnrs_pkg::*; #(
  parameter int unsigned MaxClients = MaxClientsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  in_t                 in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_t                out_o,
  input  cmd_t                cmd_i,
  output status_t             st_o
);

  localparam int unsigned IdxW = (MaxClients > 1) ? $clog2(MaxClients) : 1;
  localparam int unsigned KW = $clog2(MaxClients + 1);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(MaxClients - 1);
  localparam logic [KW-1:0] KLast = KW'(MaxClients);

  logic [15:0] timeout_q, pause_ms_q, period_q;
  in_t         in_q;
  logic [IdxW-1:0] idx_q, cursor_q;
  logic [KW-1:0]   k_q;
  logic        active_q, pause_q;
  logic [15:0] ctt_q, pst_q;
  logic        send_q, checked_q;
  logic [7:0]  dest_q;
  logic        out_valid_q;
  out_t        out_q;

  logic        valid_q [MaxClients];
  logic [7:0]  addr_q [MaxClients];
  logic [7:0]  limit_q [MaxClients];
  logic [7:0]  count_q [MaxClients];
  phase_e      phase_q [MaxClients];
  logic [15:0] sent_q [MaxClients];

  logic            any_valid;
  logic [IdxW-1:0] first_idx;
  logic [IdxW-1:0] idx_inc, cursor_inc;
  logic [6:0]      slot_ext;
  logic [IdxW-1:0] slot_idx;
  logic [15:0]     chk_el, pause_el, sent_el;

  always_comb begin
    any_valid = 1'b0;
    first_idx = '0;
    for (int i = MaxClients - 1; i >= 0; i--) begin
      if (valid_q[i]) begin
        any_valid = 1'b1;
        first_idx = IdxW'(i);
      end
    end
  end

  assign idx_inc = (idx_q == IdxLast) ? '0 : idx_q + 1'b1;
  assign cursor_inc = (cursor_q == IdxLast) ? '0 : cursor_q + 1'b1;
  assign slot_ext = {3'b000, in_q.slot};
  assign slot_idx = IdxW'(slot_ext);
  assign chk_el = in_q.now_ms - ctt_q;
  assign pause_el = in_q.now_ms - pst_q;
  assign sent_el = in_q.now_ms - sent_q[idx_q];

  always_comb begin
    st_o.cmd = in_q.cmd;
    st_o.any_valid = any_valid;
    st_o.check_due = (chk_el >= period_q);
    st_o.differs = in_q.snapshot_differs;
    st_o.active = active_q;
    st_o.pause_wait = pause_q && (pause_el < pause_ms_q);
    st_o.entry_valid = valid_q[idx_q];
    st_o.entry_phase = phase_q[idx_q];
    st_o.send_ready = in_q.send_ready;
    st_o.timeout_due = (sent_el >= timeout_q);
    st_o.retry_avail = (count_q[idx_q] < limit_q[idx_q]);
    st_o.addr_match = (addr_q[idx_q] == in_q.sender_address);
    st_o.payload_matches = in_q.payload_matches;
    st_o.idx_last = (idx_q == IdxLast);
    st_o.k_last = (k_q == KLast);
    st_o.slot_ok = (slot_ext < 7'(MaxClients));
    st_o.out_free = !out_valid_q || !out_stall_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
      pause_ms_q <= PauseReset;
      period_q <= PeriodReset;
      active_q <= 1'b0;
      pause_q <= 1'b0;
      ctt_q <= '0;
      pst_q <= '0;
      cursor_q <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MaxClients; i++) begin
        valid_q[i] <= 1'b0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegTimeout: timeout_q <= cfg_data_i;
          RegPause: pause_ms_q <= cfg_data_i;
          RegPeriod: period_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.set_checked) begin
        ctt_q <= in_q.now_ms;
      end
      if (cmd_i.start_round) begin
        active_q <= 1'b1;
        cursor_q <= first_idx;
        pause_q <= 1'b0;
      end
      if (cmd_i.pause_clear) begin
        pause_q <= 1'b0;
      end
      if (cmd_i.search_hit) begin
        cursor_q <= idx_q;
        if (idx_q <= cursor_q) begin
          pause_q <= 1'b1;
          pst_q <= in_q.now_ms;
        end
      end
      if (cmd_i.round_end) begin
        active_q <= 1'b0;
      end
      if (cmd_i.load_entry) begin
        valid_q[slot_idx] <= (in_q.client_address != AddrEmpty);
        active_q <= 1'b0;
        pause_q <= 1'b0;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      in_q <= in_i;
      send_q <= 1'b0;
      dest_q <= '0;
      checked_q <= 1'b0;
    end
    if (cmd_i.set_checked) begin
      checked_q <= 1'b1;
    end
    if (cmd_i.idx_zero) begin
      idx_q <= '0;
    end else if (cmd_i.idx_cursor) begin
      idx_q <= cursor_q;
    end else if (cmd_i.idx_search_start) begin
      idx_q <= cursor_inc;
      k_q <= KW'(1);
    end else if (cmd_i.idx_next) begin
      idx_q <= idx_inc;
      k_q <= k_q + 1'b1;
    end
    if (cmd_i.clear_entry) begin
      phase_q[idx_q] <= PH_SEND;
      count_q[idx_q] <= '0;
    end
    if (cmd_i.send_entry) begin
      phase_q[idx_q] <= PH_WAIT;
      sent_q[idx_q] <= in_q.now_ms;
      send_q <= 1'b1;
      dest_q <= addr_q[idx_q];
    end
    if (cmd_i.retry_entry) begin
      phase_q[idx_q] <= PH_SEND;
      count_q[idx_q] <= count_q[idx_q] + 1'b1;
    end
    if (cmd_i.done_entry) begin
      phase_q[idx_q] <= PH_DONE;
    end
    if (cmd_i.confirm_entry) begin
      phase_q[idx_q] <= PH_OK;
    end
    if (cmd_i.load_entry) begin
      phase_q[slot_idx] <= PH_SEND;
      count_q[slot_idx] <= '0;
      if (in_q.client_address != AddrEmpty) begin
        addr_q[slot_idx] <= in_q.client_address;
        limit_q[slot_idx] <= in_q.max_retries;
      end
    end
    if (cmd_i.out_load) begin
      out_q.send_request <= send_q;
      out_q.dest_address <= dest_q;
      out_q.change_checked <= checked_q;
      out_q.round_active <= active_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o = out_q;

endmodule

// ===== rtl/core/client_notify_retry_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// client_notify_retry_scheduler_top
// Round-robin change notification of bus clients with confirmation retries.
// ----------------------------------------------------------------------------
// Input channel in_valid_i/in_stall_o carries one command per transaction:
// poll (time, change flag, transmitter ready), confirmation, or table load.
// Output channel out_valid_o/out_stall_i returns exactly one result per
// command. cfg_we_i writes response timeout, round pause or change period.
// A confirmation scans the table. On a poll, one sweep clears the table
// when a round starts, and a second sweep over the table finds the next
// pending client after the cursor moves.
// One command is processed at a time; the next is taken once the current
// result sits in the output register, so an output stall holds at most
// one finished result while the next command is accepted.
// Reset empties the table, stops any round and loads the default timings.
// ----------------------------------------------------------------------------
module client_notify_retry_scheduler_top import cnrs_pkg::*; #(
  parameter int unsigned MaxClients = MaxClientsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_t                 in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_t                out_o
);

  cmd_t    cmd;
  status_t st;

  cnrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  cnrs_dp #(
    .MaxClients (MaxClients)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o),
    .cmd_i       (cmd),
    .st_o        (st)
  );

endmodule
